// ===== rtl/core/bit_sliced_counter_bank_assert.svh =====
// assertion macros for the bit-sliced counter bank
// used by modules that include this header; needs clk and rst_n in scope
`ifndef BIT_SLICED_COUNTER_BANK_ASSERT_SVH
`define BIT_SLICED_COUNTER_BANK_ASSERT_SVH

// same-cycle implication
`define BSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit_sliced_counter_bank: same-cycle check failed");

// next-cycle implication
`define BSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit_sliced_counter_bank: next-cycle check failed");

`endif

// ===== rtl/core/bsc_pkg.sv =====
// shared types and constants for the bit-sliced counter bank
// no dependencies
package bsc_pkg;

    localparam int WORD_W = 64;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 4;
    localparam int SUB_W  = 8;
    localparam int SEL_W  = 3;
    localparam int LANES  = 4;
    localparam int LANE_W = WORD_W / LANES;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_SUB  = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic             do_add;
        logic             do_sub;
        logic [CNT_W-1:0] add_count;
        logic [SUB_W-1:0] sub_value;
    } lane_ctrl_t;

endpackage

// ===== rtl/core/bsc_if.sv =====
// request and response channel interfaces for the counter bank
// depends on bsc_pkg
interface bsc_req_if import bsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] syndrome_word;
    logic [CNT_W-1:0]  slice_count;
    logic [SUB_W-1:0]  subtract_value;
    logic [SEL_W-1:0]  slice_select;

    modport source (
        output valid, cmd, word_index, syndrome_word, slice_count,
               subtract_value, slice_select,
        input  ready
    );
    modport sink (
        input  valid, cmd, word_index, syndrome_word, slice_count,
               subtract_value, slice_select,
        output ready
    );
endinterface

interface bsc_rsp_if import bsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_word;

    modport source (output valid, read_word, input ready);
    modport sink (input valid, read_word, output ready);
endinterface

// ===== rtl/core/bit_sliced_counter_bank.sv =====
// bit-sliced counter bank: WORDS x 64 counters of SLICES bits, one row per word index
// result: request and row are registered, then the result word is registered at the output
// one request word at a time: row read, then row write-back on one memory
// a result waiting at the output holds the word in execute and keeps ready low
// reset: a sweep over all WORDS rows zeroes the memory, ready stays low until it ends
// depends on bsc_pkg, bsc_if, bsc_lane, bsc_merge
module bit_sliced_counter_bank import bsc_pkg::*; #(
    parameter int WORDS  = 256,
    parameter int SLICES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    bsc_req_if.sink   req,
    bsc_rsp_if.source rsp
);

`include "bit_sliced_counter_bank_assert.svh"

    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [SLICES-1:0][WORD_W-1:0] mem [WORDS];

    state_t                         state_reg, state_next;
    logic [ADDR_W-1:0]              clr_reg, clr_next;
    logic                           out_valid_reg, out_valid_next;

    logic [1:0]                     cmd_reg;
    logic [ADDR_W-1:0]              addr_reg;
    logic                           idx_ok_reg;
    logic [WORD_W-1:0]              syn_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [SUB_W-1:0]               val_reg;
    logic [SEL_W-1:0]               sel_reg;
    logic [SLICES-1:0][WORD_W-1:0]  rd_row_reg;
    logic [WORD_W-1:0]              read_word_reg;

    logic                           accept;
    logic                           advance;
    logic                           exec_we;
    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [SLICES-1:0][WORD_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]              req_addr;
    logic                           req_idx_ok;

    lane_ctrl_t                                ctrl;
    logic [LANES-1:0][SLICES-1:0][LANE_W-1:0]  lane_in;
    logic [LANES-1:0][SLICES-1:0][LANE_W-1:0]  lane_out;
    logic [SLICES-1:0][WORD_W-1:0]             merged_row;
    logic [WORD_W-1:0]                         merged_read;
    logic                                      rd_ok;

    assign req_addr   = ADDR_W'(req.word_index);
    assign req_idx_ok = (32'(req.word_index) < 32'(WORDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        req.ready      = 1'b0;
        accept         = 1'b0;
        advance        = 1'b0;
        exec_we        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = merged_row;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                accept    = req.valid;
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the word here until the output register is free
                advance = !out_valid_reg || rsp.ready;
                if (advance)
                begin
                    exec_we        = idx_ok_reg && ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB));
                    mem_we         = exec_we;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_row_reg <= mem[req_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            addr_reg   <= req_addr;
            idx_ok_reg <= req_idx_ok;
            syn_reg    <= req.syndrome_word;
            cnt_reg    <= req.slice_count;
            val_reg    <= req.subtract_value;
            sel_reg    <= req.slice_select;
        end
        if (advance)
        begin
            read_word_reg <= merged_read;
        end
    end

    assign ctrl.do_add    = (cmd_reg == CMD_ADD);
    assign ctrl.do_sub    = (cmd_reg == CMD_SUB);
    assign ctrl.add_count = cnt_reg;
    assign ctrl.sub_value = val_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            for (int j = 0; j < SLICES; j++)
            begin
                lane_in[l][j] = rd_row_reg[j][l*LANE_W +: LANE_W];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        bsc_lane #(
            .SLICES (SLICES)
        ) u_lane (
            .ctrl       (ctrl),
            .syn_bits   (syn_reg[l*LANE_W +: LANE_W]),
            .slices_in  (lane_in[l]),
            .slices_out (lane_out[l])
        );
    end

    assign rd_ok = idx_ok_reg && (cmd_reg == CMD_READ);

    bsc_merge #(
        .SLICES (SLICES)
    ) u_merge (
        .lane_row  (lane_out),
        .rd_row    (rd_row_reg),
        .rd_ok     (rd_ok),
        .sel       (sel_reg),
        .wr_row    (merged_row),
        .read_word (merged_read)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_word = read_word_reg;

    `BSC_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, !req.ready)
    `BSC_ASSERT_NEXT(a_accept_goes_exec, req.valid && req.ready, state_reg == ST_EXEC)
    `BSC_ASSERT_NOW(a_write_only_valid_index, exec_we, idx_ok_reg && (state_reg == ST_EXEC))
    `BSC_ASSERT_NEXT(a_exec_loads_output, (state_reg == ST_EXEC) && advance, rsp.valid)

endmodule

// ===== rtl/core/bsc_lane.sv =====
// one lane: add ripple and subtract borrow chain over a 16-column slice group
// depends on bsc_pkg
module bsc_lane import bsc_pkg::*; #(
    parameter int SLICES = 8
) (
    input  lane_ctrl_t                          ctrl,
    input  logic [LANE_W-1:0]                   syn_bits,
    input  logic [SLICES-1:0][LANE_W-1:0]       slices_in,
    output logic [SLICES-1:0][LANE_W-1:0]       slices_out
);

    logic [SLICES-1:0] sub_ext;

    assign sub_ext = SLICES'(ctrl.sub_value);

    always_comb
    begin
        logic [LANE_W-1:0] carry;
        logic [LANE_W-1:0] borrow;
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        carry  = syn_bits;
        borrow = '0;
        for (int j = 0; j < SLICES; j++)
        begin
            a = slices_in[j];
            b = {LANE_W{sub_ext[j]}};
            slices_out[j] = a;
            if (ctrl.do_add && (j < int'(ctrl.add_count)))
            begin
                slices_out[j] = a ^ carry;
                carry         = a & carry;
            end
            else if (ctrl.do_sub)
            begin
                slices_out[j] = a ^ b ^ borrow;
                borrow        = (~a & b & ~borrow) | ((~a | b) & borrow);
            end
        end
    end

endmodule

// ===== rtl/core/bsc_merge.sv =====
// merges lane results into one row and selects the slice word for a read
// depends on bsc_pkg
module bsc_merge import bsc_pkg::*; #(
    parameter int SLICES = 8
) (
    input  logic [LANES-1:0][SLICES-1:0][LANE_W-1:0] lane_row,
    input  logic [SLICES-1:0][WORD_W-1:0]            rd_row,
    input  logic                                     rd_ok,
    input  logic [SEL_W-1:0]                         sel,
    output logic [SLICES-1:0][WORD_W-1:0]            wr_row,
    output logic [WORD_W-1:0]                        read_word
);

    always_comb
    begin
        for (int j = 0; j < SLICES; j++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                wr_row[j][l*LANE_W +: LANE_W] = lane_row[l][j];
            end
        end
    end

    // select out of range returns zero
    always_comb
    begin
        read_word = '0;
        for (int j = 0; j < SLICES; j++)
        begin
            if (rd_ok && (int'(sel) == j))
            begin
                read_word = rd_row[j];
            end
        end
    end

endmodule

// ===== tb/tb_bit_sliced_counter_bank.sv =====
// self-checking testbench for bit_sliced_counter_bank: random and directed command words,
// a counter image predicts every read_word; random stalls on both channels
// depends on bsc_pkg, bsc_if and the bit_sliced_counter_bank rtl
module tb_bit_sliced_counter_bank;
    import bsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WORDS   = 256;
    localparam int NUM_SLICES  = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    // command code that the bank ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    bsc_req_if req_ch ();
    bsc_rsp_if rsp_ch ();

    bit_sliced_counter_bank #(
        .WORDS  (NUM_WORDS),
        .SLICES (NUM_SLICES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4ns clk = ~clk;

    // counter image: entry idx*NUM_SLICES + j holds slice j of the 64 counters at idx
    logic [WORD_W-1:0] counter_image [NUM_WORDS*NUM_SLICES];
    logic [WORD_W-1:0] expected_words [$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_hold_cycles = 0;
    int hot_idx [4];

    function automatic logic [WORD_W-1:0] predict_read_word(
        input logic [1:0]        op,
        input logic [IDX_W-1:0]  idx,
        input logic [WORD_W-1:0] syn,
        input logic [CNT_W-1:0]  cnt,
        input logic [SUB_W-1:0]  val,
        input logic [SEL_W-1:0]  sel
    );
        int                base;
        int                span;
        logic [WORD_W-1:0] carry;
        logic [WORD_W-1:0] cur;
        logic [WORD_W-1:0] sub_bits;
        logic [WORD_W-1:0] borrow;
        logic [WORD_W-1:0] next_borrow;
        logic              in_bank;

        in_bank = (int'(idx) < NUM_WORDS);
        base    = int'(idx) * NUM_SLICES;
        if (!in_bank)
        begin
            return '0;
        end
        case (op)
            CMD_ADD:
            begin
                span  = (int'(cnt) > NUM_SLICES) ? NUM_SLICES : int'(cnt);
                carry = syn;
                for (int j = 0; j < span; j++)
                begin
                    cur = counter_image[base + j];
                    counter_image[base + j] = cur ^ carry;
                    carry = cur & carry;
                end
                return '0;
            end
            CMD_SUB:
            begin
                borrow = '0;
                for (int j = 0; j < NUM_SLICES; j++)
                begin
                    cur      = counter_image[base + j];
                    sub_bits = (j < SUB_W && val[j]) ? '1 : '0;
                    next_borrow = (~cur & sub_bits & ~borrow) | ((~cur | sub_bits) & borrow);
                    counter_image[base + j] = cur ^ sub_bits ^ borrow;
                    borrow = next_borrow;
                end
                return '0;
            end
            CMD_READ:
            begin
                if (int'(sel) < NUM_SLICES)
                begin
                    return counter_image[base + int'(sel)];
                end
                return '0;
            end
            default:
            begin
                return '0;
            end
        endcase
    endfunction

    task automatic tx_gap();
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_word(
        input logic [1:0]        op,
        input logic [IDX_W-1:0]  idx,
        input logic [WORD_W-1:0] syn,
        input logic [CNT_W-1:0]  cnt,
        input logic [SUB_W-1:0]  val,
        input logic [SEL_W-1:0]  sel
    );
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= op;
        req_ch.word_index     <= idx;
        req_ch.syndrome_word  <= syn;
        req_ch.slice_count    <= cnt;
        req_ch.subtract_value <= val;
        req_ch.slice_select   <= sel;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        expected_words.push_back(predict_read_word(op, idx, syn, cnt, val, sel));
        tx_gap();
    endtask

    task automatic send_random_word();
        int                pick;
        logic [1:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] syn;
        logic [CNT_W-1:0]  cnt;

        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = CMD_ADD;
        else if (pick < 55)
            op = CMD_SUB;
        else if (pick < 95)
            op = CMD_READ;
        else
            op = CMD_UNUSED;

        // most traffic lands on a few indices so counters build up and wrap
        if ($urandom_range(0, 3) != 0)
            idx = IDX_W'(hot_idx[$urandom_range(0, 3)]);
        else
            idx = IDX_W'($urandom_range(0, NUM_WORDS - 1));

        pick = $urandom_range(0, 19);
        if (pick < 16)
            syn = {$urandom, $urandom};
        else if (pick == 16)
            syn = '1;
        else if (pick == 17)
            syn = '0;
        else
            syn = 64'd1 << $urandom_range(0, WORD_W - 1);

        pick = $urandom_range(0, 9);
        if (pick < 8)
            cnt = CNT_W'($urandom_range(1, NUM_SLICES));
        else if (pick == 8)
            cnt = '0;
        else
            cnt = CNT_W'($urandom_range(NUM_SLICES + 1, 15));

        send_word(op, idx, syn, cnt, SUB_W'($urandom_range(0, 255)),
                  SEL_W'($urandom_range(0, 7)));
    endtask

    task automatic pick_hot_indices();
        for (int k = 0; k < 4; k++)
        begin
            hot_idx[k] = $urandom_range(0, NUM_WORDS - 1);
        end
        if ($urandom_range(0, 1) != 0)
            hot_idx[0] = 0;
        if ($urandom_range(0, 1) != 0)
            hot_idx[1] = NUM_WORDS - 1;
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_cleared_bank();
        send_word(CMD_READ, 8'd0,   '0, '0, '0, 3'd0);
        send_word(CMD_READ, 8'd255, '0, '0, '0, 3'd7);
        send_word(CMD_READ, 8'h5a,  '0, '0, '0, 3'd3);
    endtask

    task automatic test_add_edges();
        send_word(CMD_ADD,  8'd0, '1, 4'd8, '0, '0);
        // slice count above the counter width saturates
        send_word(CMD_ADD,  8'd0, '1, 4'd15, '0, '0);
        // zero slice count leaves the counters alone
        send_word(CMD_ADD,  8'd0, 64'haaaa_aaaa_aaaa_aaaa, 4'd0, '0, '0);
        send_word(CMD_READ, 8'd0, '0, '0, '0, 3'd0);
        send_word(CMD_READ, 8'd0, '0, '0, '0, 3'd1);
        send_word(CMD_ADD,  8'd255, 64'h8000_0000_0000_0001, 4'd1, '0, '0);
        send_word(CMD_READ, 8'd255, '0, '0, '0, 3'd0);
    endtask

    task automatic test_subtract_edges();
        // borrow out of zero wraps every counter to all ones
        send_word(CMD_SUB,  8'd1, '0, '0, 8'd1, '0);
        send_word(CMD_READ, 8'd1, '0, '0, '0, 3'd0);
        send_word(CMD_READ, 8'd1, '0, '0, '0, 3'd7);
        // carry out of the top slice is dropped
        send_word(CMD_ADD,  8'd1, '1, 4'd8, '0, '0);
        send_word(CMD_READ, 8'd1, '0, '0, '0, 3'd7);
        send_word(CMD_SUB,  8'd2, '0, '0, 8'd255, '0);
        send_word(CMD_SUB,  8'd2, '0, '0, 8'd0, '0);
        send_word(CMD_SUB,  8'd0, '0, '0, 8'h80, '0);
        send_word(CMD_READ, 8'd2, '0, '0, '0, 3'd4);
        send_word(CMD_READ, 8'd0, '0, '0, '0, 3'd7);
    endtask

    task automatic test_unused_cmd();
        send_word(CMD_UNUSED, 8'd0, '1, 4'd8, 8'hff, 3'd7);
        send_word(CMD_READ,   8'd0, '0, '0, '0, 3'd1);
    endtask

    task automatic test_random_mix();
        int modes [3] = '{0, 10, 30};

        for (int blk = 0; blk < 10; blk++)
        begin
            tx_idle_pct = modes[$urandom_range(0, 2)];
            rx_idle_pct = modes[$urandom_range(0, 2)];
            pick_hot_indices();
            repeat (100) send_random_word();
        end
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct    = 0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (40) send_random_word();
    endtask

    task automatic test_sender_pause();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        repeat (30) send_random_word();
        wait_for_results();
        repeat (30) send_random_word();
    endtask

    task automatic test_streaming();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pick_hot_indices();
        repeat (200) send_random_word();
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        logic [WORD_W-1:0] want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("read_word: expected none, actual %h", rsp_ch.read_word);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_ch.read_word !== want)
                begin
                    $error("read_word: expected %h, actual %h", want, rsp_ch.read_word);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.cmd            <= CMD_ADD;
        req_ch.word_index     <= '0;
        req_ch.syndrome_word  <= '0;
        req_ch.slice_count    <= '0;
        req_ch.subtract_value <= '0;
        req_ch.slice_select   <= '0;
        for (int k = 0; k < NUM_WORDS * NUM_SLICES; k++)
        begin
            counter_image[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_bank();
        test_add_edges();
        test_subtract_edges();
        test_unused_cmd();
        test_random_mix();
        test_output_backpressure();
        test_sender_pause();
        test_streaming();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_if.sv
rtl/core/bsc_lane.sv
rtl/core/bsc_merge.sv
rtl/core/bit_sliced_counter_bank.sv
tb/tb_bit_sliced_counter_bank.sv
